// File: src/grid_local_minimum_risk_sum_assert.svh
// Assertion macros used by the checker file of the low-point detector.
`ifndef GRID_LOCAL_MINIMUM_RISK_SUM_ASSERT_SVH
`define GRID_LOCAL_MINIMUM_RISK_SUM_ASSERT_SVH

// Check a property while the block is out of reset.
`define GLMRS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("glmrs: property failed");

// Check a property on every rising clock edge, reset included.
`define GLMRS_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("glmrs: property failed");

`endif

// File: src/glmrs_pkg.sv
package glmrs_pkg;

    // Default frame limits
    localparam int MAX_COLS_DEF = 128;
    localparam int MAX_ROWS_DEF = 1024;

    // Field widths
    localparam int HEIGHT_W    = 4;
    localparam int RISK_W      = 21;
    localparam int COLS_CFG_W  = 8;
    localparam int ROWS_CFG_W  = 11;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_ADDR_W  = 1;
    localparam int S_TDATA_W   = 8;

    localparam logic [RISK_W-1:0] RISK_MAX = {RISK_W{1'b1}};

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_NUM_COLS = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_NUM_ROWS = 1'b1;

    // Configuration reset values
    localparam logic [COLS_CFG_W-1:0] NUM_COLS_RST = 8'd128;
    localparam logic [ROWS_CFG_W-1:0] NUM_ROWS_RST = 11'd1024;

    // Result queue: up to three results pushed per item, one popped per cycle
    localparam int MAX_PUSH    = 3;
    localparam int PUSH_CNT_W  = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    // Push request into the result queue
    typedef struct packed {
        logic [PUSH_CNT_W-1:0] cnt;
    } t_push_req;

endpackage

// File: src/glmrs_ram.sv
module glmrs_ram #(
    parameter int WIDTH = glmrs_pkg::HEIGHT_W,
    parameter int DEPTH = glmrs_pkg::MAX_COLS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/glmrs_rqueue.sv
module glmrs_rqueue #(
    parameter int WIDTH = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  glmrs_pkg::t_push_req                 i_push,
    input  logic [WIDTH-1:0]                     i_push_data [glmrs_pkg::MAX_PUSH],
    output logic [glmrs_pkg::QUEUE_CNT_W-1:0]    o_free,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [WIDTH-1:0]                     o_data
);

    logic [WIDTH-1:0]                  r_mem [glmrs_pkg::QUEUE_DEPTH];
    logic [glmrs_pkg::QUEUE_PTR_W-1:0] r_wr;
    logic [glmrs_pkg::QUEUE_PTR_W-1:0] r_rd;
    logic [glmrs_pkg::QUEUE_CNT_W-1:0] r_cnt;
    logic                              w_pop;

    assign w_pop   = (r_cnt != '0) && i_ready;
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign o_free  = glmrs_pkg::QUEUE_CNT_W'(glmrs_pkg::QUEUE_DEPTH) - r_cnt;

    // Store pushed items at consecutive slots after the tail
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < glmrs_pkg::MAX_PUSH; i++) begin
            if (glmrs_pkg::PUSH_CNT_W'(i) < i_push.cnt) begin
                r_mem[r_wr + glmrs_pkg::QUEUE_PTR_W'(i)] <= i_push_data[i];
            end
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + glmrs_pkg::QUEUE_PTR_W'(i_push.cnt);
            r_rd  <= r_rd + glmrs_pkg::QUEUE_PTR_W'(w_pop);
            r_cnt <= r_cnt + glmrs_pkg::QUEUE_CNT_W'(i_push.cnt)
                           - glmrs_pkg::QUEUE_CNT_W'(w_pop);
        end
    end

endmodule

// File: src/grid_local_minimum_risk_sum.sv
// Channel   Direction  Payload                                            Handshake
// s_axis    in         tdata: height                                      tvalid/tready
// m_axis    out        tdata: point_row, point_col, is_low,               tvalid/tready
//                             point_height, risk_sum; tlast: last_of_run;
//                             tuser: frame_done
// cfg       in         index 0 num_cols, index 1 num_rows                 i_cfg_we
//
// An item is taken every cycle while the result queue has room for its results. It waits
// in the input register, where the three line-store reads land, then its results enter
// the four-entry result queue.
// In the last row an item yields up to three results while the output drains one
// per cycle, so there the input slows to the output rate as the result queue fills.
// Reset is synchronous, active low; the line stores are not cleared.
// An output stall fills the result queue, then holds the input register and tready.
module grid_local_minimum_risk_sum #(
    parameter int MAX_COLS = glmrs_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = glmrs_pkg::MAX_ROWS_DEF,
    localparam int CW = $clog2(MAX_COLS),
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int FIELD_W = RW + CW + 1 + glmrs_pkg::HEIGHT_W + glmrs_pkg::RISK_W,
    localparam int TDATA_W = ((FIELD_W + 7) / 8) * 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [glmrs_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [glmrs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input stream
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [glmrs_pkg::S_TDATA_W-1:0]     i_s_axis_tdata,  // [3:0] height
    // result stream
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // point_row, point_col, is_low, point_height, risk_sum from bit 0 up
    output logic [TDATA_W-1:0]                  o_m_axis_tdata,
    output logic                                o_m_axis_tlast,  // last_of_run
    output logic [0:0]                          o_m_axis_tuser   // frame_done
);

    localparam int HW    = glmrs_pkg::HEIGHT_W;
    localparam int SW    = glmrs_pkg::RISK_W;
    localparam int CDW   = $clog2(MAX_COLS + 1);
    localparam int RDW   = $clog2(MAX_ROWS + 1);
    localparam int RES_W = FIELD_W + 2;
    localparam int PUSH_CNT_W_L = glmrs_pkg::PUSH_CNT_W;

    // Configuration registers
    logic [glmrs_pkg::COLS_CFG_W-1:0] r_num_cols;
    logic [glmrs_pkg::ROWS_CFG_W-1:0] r_num_rows;
    logic [CDW-1:0]                   w_cols;
    logic [RDW-1:0]                   w_rows;

    // Input position counters
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic          w_row_end;
    logic          w_last_row;
    logic          w_accept;

    // Input register
    logic          r_in_vld;
    logic [HW-1:0] r_px;
    logic [CW-1:0] r_c;
    logic [RW-1:0] r_r;
    logic          r_row_end;
    logic          r_last_row;

    // Line-store read bypass
    logic          r_hit_mid;
    logic          r_hit_east;
    logic [HW-1:0] r_byp_px;
    logic [HW-1:0] r_byp_up;

    // Line-store ports
    logic [HW-1:0] w_mid_q;
    logic [HW-1:0] w_east_q;
    logic [HW-1:0] w_up_q;
    logic [CW-1:0] w_east_addr;
    logic [HW-1:0] w_mid;
    logic [HW-1:0] w_east;
    logic [HW-1:0] w_up;

    // Neighborhood state
    logic [HW-1:0] r_west;
    logic [HW-1:0] r_win0;
    logic [HW-1:0] r_win1;
    logic [SW-1:0] r_risk;

    // Decision logic
    logic          w_has_a;
    logic          w_has_b;
    logic          w_has_c;
    logic          w_low_a;
    logic          w_low_b;
    logic          w_low_c;
    logic [SW-1:0] w_sum_a;
    logic [SW-1:0] w_sum_b;
    logic [SW-1:0] w_sum_c;
    logic [RW-1:0] w_row_above;
    logic [CW-1:0] w_col_west;
    logic          w_consume;

    // Result queue
    glmrs_pkg::t_push_req               w_push;
    logic [RES_W-1:0]                   w_push_data [glmrs_pkg::MAX_PUSH];
    logic [glmrs_pkg::QUEUE_CNT_W-1:0]  w_free;
    logic                               w_q_valid;
    logic [RES_W-1:0]                   w_q_data;

    // Add one plus height to the running sum for a low point, saturating
    function automatic logic [SW-1:0] f_risk_add(input logic [SW-1:0] s, input logic low,
                                                 input logic [HW-1:0] h);
        logic [SW:0] sum;
        sum = {1'b0, s} + (low ? ((SW+1)'(h) + (SW+1)'(1)) : '0);
        return sum[SW] ? glmrs_pkg::RISK_MAX : sum[SW-1:0];
    endfunction

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_cols <= glmrs_pkg::NUM_COLS_RST;
            r_num_rows <= glmrs_pkg::NUM_ROWS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                glmrs_pkg::REG_NUM_COLS: r_num_cols <= i_cfg_data[glmrs_pkg::COLS_CFG_W-1:0];
                glmrs_pkg::REG_NUM_ROWS: r_num_rows <= i_cfg_data[glmrs_pkg::ROWS_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Saturate frame sizes to 1..MAX
    always_comb begin
        if (r_num_cols == '0) begin
            w_cols = CDW'(1);
        end else if (32'(r_num_cols) > 32'(MAX_COLS)) begin
            w_cols = CDW'(MAX_COLS);
        end else begin
            w_cols = CDW'(r_num_cols);
        end
        if (r_num_rows == '0) begin
            w_rows = RDW'(1);
        end else if (32'(r_num_rows) > 32'(MAX_ROWS)) begin
            w_rows = RDW'(MAX_ROWS);
        end else begin
            w_rows = RDW'(r_num_rows);
        end
    end

    assign w_row_end  = (32'(r_col) + 32'd1) >= 32'(w_cols);
    assign w_last_row = (32'(r_row) + 32'd1) >= 32'(w_rows);

    // Handshake: take an item when the input register is empty or draining
    assign w_consume       = r_in_vld &&
                             (w_free >= glmrs_pkg::QUEUE_CNT_W'(w_push.cnt));
    assign o_s_axis_tready = !r_in_vld || w_consume;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // Advance the column and row of the next item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_accept) begin
            if (w_row_end) begin
                r_col <= '0;
                r_row <= w_last_row ? '0 : r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // Load the input register and the read bypass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_accept) begin
            r_in_vld <= 1'b1;
        end else if (w_consume) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_px       <= i_s_axis_tdata[HW-1:0];
            r_c        <= r_col;
            r_r        <= r_row;
            r_row_end  <= w_row_end;
            r_last_row <= w_last_row;
            r_hit_mid  <= w_consume && (r_c == r_col);
            r_hit_east <= w_consume && (r_c == w_east_addr);
            r_byp_px   <= r_px;
            r_byp_up   <= w_mid;
        end
    end

    assign w_east_addr = r_col + CW'(1);

    // Line stores: middle row read at the column and its east side, upper row
    glmrs_ram #(.WIDTH(HW), .DEPTH(MAX_COLS)) u_mid_ram (
        .i_clk   (i_clk),
        .i_we    (w_consume),
        .i_waddr (r_c),
        .i_wdata (r_px),
        .i_re    (w_accept),
        .i_raddr (r_col),
        .o_rdata (w_mid_q)
    );

    glmrs_ram #(.WIDTH(HW), .DEPTH(MAX_COLS)) u_east_ram (
        .i_clk   (i_clk),
        .i_we    (w_consume),
        .i_waddr (r_c),
        .i_wdata (r_px),
        .i_re    (w_accept),
        .i_raddr (w_east_addr),
        .o_rdata (w_east_q)
    );

    glmrs_ram #(.WIDTH(HW), .DEPTH(MAX_COLS)) u_up_ram (
        .i_clk   (i_clk),
        .i_we    (w_consume),
        .i_waddr (r_c),
        .i_wdata (w_mid),
        .i_re    (w_accept),
        .i_raddr (r_col),
        .o_rdata (w_up_q)
    );

    assign w_mid  = r_hit_mid  ? r_byp_px : w_mid_q;
    assign w_east = r_hit_east ? r_byp_px : w_east_q;
    assign w_up   = r_hit_mid  ? r_byp_up : w_up_q;

    // Decide the cell above, the west cell of the last row, and the row's final cell
    assign w_has_a = (r_r != '0);
    assign w_has_b = r_last_row && (r_c != '0);
    assign w_has_c = r_last_row && r_row_end;

    assign w_low_a = ((r_r == RW'(1)) || (w_up > w_mid)) &&
                     (r_row_end || (w_east > w_mid)) &&
                     (r_px > w_mid) &&
                     ((r_c == '0) || (r_west > w_mid));
    assign w_low_b = ((r_r == '0) || (r_west > r_win0)) &&
                     (r_px > r_win0) &&
                     ((r_c == CW'(1)) || (r_win1 > r_win0));
    assign w_low_c = ((r_r == '0) || (w_mid > r_px)) &&
                     ((r_c == '0) || (r_win0 > r_px));

    assign w_sum_a = f_risk_add(r_risk,  w_has_a && w_low_a, w_mid);
    assign w_sum_b = f_risk_add(w_sum_a, w_has_b && w_low_b, r_win0);
    assign w_sum_c = f_risk_add(w_sum_b, w_has_c && w_low_c, r_px);

    assign w_row_above = r_r - RW'(1);
    assign w_col_west  = r_c - CW'(1);

    // Pack the present results in order into the push slots
    always_comb begin
        logic [PUSH_CNT_W_L-1:0] k;
        k = '0;
        for (int i = 0; i < glmrs_pkg::MAX_PUSH; i++) begin
            w_push_data[i] = '0;
        end
        if (w_has_a) begin
            w_push_data[k] = {1'b0, !w_has_b && !w_has_c, w_sum_a, w_mid, w_low_a,
                              r_c, w_row_above};
            k = k + PUSH_CNT_W_L'(1);
        end
        if (w_has_b) begin
            w_push_data[k] = {1'b0, !w_has_c, w_sum_b, r_win0, w_low_b, w_col_west, r_r};
            k = k + PUSH_CNT_W_L'(1);
        end
        if (w_has_c) begin
            w_push_data[k] = {1'b1, 1'b1, w_sum_c, r_px, w_low_c, r_c, r_r};
            k = k + PUSH_CNT_W_L'(1);
        end
        w_push.cnt = k;
    end

    // Update neighborhood state and the running sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_west <= '0;
            r_win0 <= '0;
            r_win1 <= '0;
            r_risk <= '0;
        end else if (w_consume) begin
            r_west <= w_mid;
            if (r_last_row) begin
                r_win1 <= r_win0;
                r_win0 <= r_px;
            end
            r_risk <= (r_row_end && r_last_row) ? '0 : w_sum_c;
        end
    end

    // Result queue between the decision logic and the output
    glmrs_rqueue #(.WIDTH(RES_W)) u_rqueue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_consume ? w_push : '0),
        .i_push_data (w_push_data),
        .o_free      (w_free),
        .o_valid     (w_q_valid),
        .i_ready     (i_m_axis_tready),
        .o_data      (w_q_data)
    );

    assign o_m_axis_tvalid = w_q_valid;
    assign o_m_axis_tdata  = TDATA_W'(w_q_data[FIELD_W-1:0]);
    assign o_m_axis_tlast  = w_q_data[FIELD_W];
    assign o_m_axis_tuser  = w_q_data[FIELD_W+1];

endmodule

// File: src/glmrs_checker.sv
`include "grid_local_minimum_risk_sum_assert.svh"

module glmrs_checker #(
    parameter int MAX_COLS = glmrs_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = glmrs_pkg::MAX_ROWS_DEF,
    localparam int CW = $clog2(MAX_COLS),
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int FIELD_W = RW + CW + 1 + glmrs_pkg::HEIGHT_W + glmrs_pkg::RISK_W,
    localparam int TDATA_W = ((FIELD_W + 7) / 8) * 8
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [TDATA_W-1:0]               o_m_axis_tdata,
    input logic                             o_m_axis_tlast,
    input logic [0:0]                       o_m_axis_tuser
);

    localparam int LOW_BIT = RW + CW;
    localparam int H_LO    = LOW_BIT + 1;
    localparam int RISK_LO = H_LO + glmrs_pkg::HEIGHT_W;

    logic                              w_vld;
    logic                              w_done;
    logic                              w_go;
    logic                              w_stall;
    logic                              w_is_low;
    logic [glmrs_pkg::HEIGHT_W:0]      w_h_plus1;
    logic [glmrs_pkg::RISK_W-1:0]      w_floor;
    logic [glmrs_pkg::RISK_W-1:0]      w_risk;

    assign w_vld     = o_m_axis_tvalid;
    assign w_done    = o_m_axis_tuser[0];
    assign w_go      = o_m_axis_tvalid && i_m_axis_tready && !w_done;
    assign w_stall   = o_m_axis_tvalid && !i_m_axis_tready;
    assign w_is_low  = o_m_axis_tdata[LOW_BIT];
    assign w_h_plus1 = {1'b0, o_m_axis_tdata[H_LO +: glmrs_pkg::HEIGHT_W]} + 1'b1;
    assign w_floor   = glmrs_pkg::RISK_W'(w_h_plus1);
    assign w_risk    = o_m_axis_tdata[RISK_LO +: glmrs_pkg::RISK_W];

    // No result is shown right after a reset edge
    `GLMRS_ASSERT_ALWAYS(a_idle_after_reset, i_clk, !i_rst_n |=> !w_vld)

    // The frame's final decision closes its run
    `GLMRS_ASSERT(a_done_is_last, i_clk, i_rst_n, w_vld && w_done |-> o_m_axis_tlast)

    // A low point is already counted in the sum it carries
    `GLMRS_ASSERT(a_low_in_sum, i_clk, i_rst_n, w_vld && w_is_low |-> (w_risk >= w_floor))

    // Within a frame the sum never falls from one result to the next
    `GLMRS_ASSERT(a_sum_rises, i_clk, i_rst_n, w_go ##1 w_vld |-> w_risk >= $past(w_risk))

    // A stalled result holds
    `GLMRS_ASSERT(a_stall_holds, i_clk, i_rst_n, w_stall |=> w_vld && $stable(o_m_axis_tdata))

endmodule

bind grid_local_minimum_risk_sum glmrs_checker #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
) u_glmrs_checker (.*);

// File: test/tb_grid_local_minimum_risk_sum.sv
`timescale 1ns / 1ps

module tb_grid_local_minimum_risk_sum;

    localparam int MAX_COLS_DEF = glmrs_pkg::MAX_COLS_DEF;
    localparam int MAX_ROWS_DEF = glmrs_pkg::MAX_ROWS_DEF;
    localparam int HEIGHT_W     = glmrs_pkg::HEIGHT_W;
    localparam int RISK_W       = glmrs_pkg::RISK_W;
    localparam int CFG_ADDR_W   = glmrs_pkg::CFG_ADDR_W;
    localparam int CFG_DATA_W   = glmrs_pkg::CFG_DATA_W;
    localparam int S_TDATA_W    = glmrs_pkg::S_TDATA_W;

    localparam int PT_COL_W   = $clog2(MAX_COLS_DEF);
    localparam int PT_ROW_W   = $clog2(MAX_ROWS_DEF);
    localparam int FIELD_W    = PT_ROW_W + PT_COL_W + 1 + HEIGHT_W + RISK_W;
    localparam int M_TDATA_W  = ((FIELD_W + 7) / 8) * 8;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 60;
    localparam int SETTLE_CYCLES = 8;

    // Result fields as packed into tdata, point_row in the lowest bits
    typedef struct packed {
        logic [RISK_W-1:0]   risk_sum;
        logic [HEIGHT_W-1:0] point_height;
        logic                is_low;
        logic [PT_COL_W-1:0] point_col;
        logic [PT_ROW_W-1:0] point_row;
    } t_point_fields;

    typedef struct packed {
        t_point_fields f;
        logic          last_of_run;
        logic          frame_done;
    } t_point_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [S_TDATA_W-1:0]   i_s_axis_tdata = '0;   // [3:0] height
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    // point_row, point_col, is_low, point_height, risk_sum from bit 0 up
    logic [M_TDATA_W-1:0]   o_m_axis_tdata;
    logic                   o_m_axis_tlast;        // last_of_run
    logic [0:0]             o_m_axis_tuser;        // frame_done

    grid_local_minimum_risk_sum dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Heights waiting to be sent and decisions waiting to come out
    logic [HEIGHT_W-1:0] height_feed[$];
    t_point_result       expected_points[$];

    // Shadow of the detector state
    logic [HEIGHT_W-1:0] upper_row[MAX_COLS_DEF];
    logic [HEIGHT_W-1:0] middle_row[MAX_COLS_DEF];
    logic [HEIGHT_W-1:0] west_h = '0;
    logic [HEIGHT_W-1:0] tail_h0 = '0;
    logic [HEIGHT_W-1:0] tail_h1 = '0;
    int                  col_pos = 0;
    int                  row_pos = 0;
    int                  risk_acc = 0;
    int                  cols_reg = MAX_COLS_DEF;
    int                  rows_reg = MAX_ROWS_DEF;

    int sent_items = 0;
    int checked_points = 0;
    int low_points = 0;
    int frames_done = 0;
    int mismatches = 0;
    int random_items = 0;

    function automatic int clamp_dim(input int v, input int maxv);
        if (v < 1) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    // Append a height to the send queue
    task automatic feed_height(input logic [HEIGHT_W-1:0] h);
        height_feed.insert(height_feed.size(), h);
    endtask

    // Build one decision and fold a low point into the running risk sum
    function automatic t_point_result make_point(input int row, input int col,
                                                 input logic [HEIGHT_W-1:0] h,
                                                 input logic low);
        t_point_result p;
        if (low) begin
            risk_acc = risk_acc + 1 + int'(h);
            if (risk_acc > int'(glmrs_pkg::RISK_MAX)) risk_acc = int'(glmrs_pkg::RISK_MAX);
        end
        p.f.point_row    = row[PT_ROW_W-1:0];
        p.f.point_col    = col[PT_COL_W-1:0];
        p.f.is_low       = low;
        p.f.point_height = h;
        p.f.risk_sum     = risk_acc[RISK_W-1:0];
        p.last_of_run    = 1'b0;
        p.frame_done     = 1'b0;
        return p;
    endfunction

    // Work out the decisions that one accepted height causes
    task automatic predict_decisions(input logic [HEIGHT_W-1:0] px);
        t_point_result res[3];
        int k;
        int cols;
        int rows;
        int c;
        int r;
        bit row_end;
        bit last_row;
        bit n_ok;
        bit e_ok;
        bit s_ok;
        bit w_ok;
        logic [HEIGHT_W-1:0] mid;
        logic [HEIGHT_W-1:0] h;
        k = 0;
        cols = clamp_dim(cols_reg, MAX_COLS_DEF);
        rows = clamp_dim(rows_reg, MAX_ROWS_DEF);
        c = col_pos % MAX_COLS_DEF;
        r = row_pos;
        row_end = (c + 1 >= cols);
        last_row = (r + 1 >= rows);

        // Decide the cell above now that its south neighbour is here
        mid = middle_row[c];
        if (r >= 1) begin
            n_ok = (r == 1) || (upper_row[c] > mid);
            e_ok = row_end || (middle_row[(c + 1) % MAX_COLS_DEF] > mid);
            s_ok = px > mid;
            w_ok = (c == 0) || (west_h > mid);
            res[k] = make_point(r - 1, c, mid, n_ok && e_ok && s_ok && w_ok);
            k++;
        end
        upper_row[c] = mid;
        middle_row[c] = px;
        west_h = mid;

        // In the last row, decide the west cell and, at the row end, this one
        if (last_row) begin
            if (c >= 1) begin
                h = tail_h0;
                n_ok = (r == 0) || (upper_row[c - 1] > h);
                e_ok = px > h;
                w_ok = (c == 1) || (tail_h1 > h);
                res[k] = make_point(r, c - 1, h, n_ok && e_ok && w_ok);
                k++;
            end
            if (row_end) begin
                n_ok = (r == 0) || (upper_row[c] > px);
                w_ok = (c == 0) || (tail_h0 > px);
                res[k] = make_point(r, c, px, n_ok && w_ok);
                k++;
            end
            tail_h1 = tail_h0;
            tail_h0 = px;
        end

        if (k > 0) res[k - 1].last_of_run = 1'b1;

        // Advance the position; clear the sum after the frame
        if (row_end) begin
            col_pos = 0;
            if (last_row) begin
                if (k > 0) res[k - 1].frame_done = 1'b1;
                row_pos = 0;
                risk_acc = 0;
            end else begin
                row_pos = r + 1;
            end
        end else begin
            col_pos = c + 1;
        end

        for (int i = 0; i < k; i++) expected_points.insert(expected_points.size(), res[i]);
    endtask

    // Sender: bursts of random length separated by random gaps
    logic [HEIGHT_W-1:0] held_height = '0;
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                predict_decisions(held_height);
                sent_items++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (height_feed.size() != 0) begin
                    held_height = height_feed.pop_front();
                    i_s_axis_tdata <= {{(S_TDATA_W - HEIGHT_W){1'b0}}, held_height};
                    i_s_axis_tvalid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                                : $urandom_range(0, 12);
                        gap_left = $urandom_range(1, 7);
                    end
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: ready runs and stalls of unrelated lengths
    int ready_left = 0;
    int stall_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
            if (ready_left > 0) begin
                ready_left--;
            end else begin
                ready_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 150)
                                                        : $urandom_range(0, 9);
                stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 25)
                                                        : $urandom_range(0, 3);
            end
        end
    end

    // Compare each accepted decision with the oldest one predicted
    always @(posedge i_clk) begin
        t_point_result got;
        t_point_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.f = o_m_axis_tdata[FIELD_W-1:0];
            got.last_of_run = o_m_axis_tlast;
            got.frame_done = o_m_axis_tuser[0];
            if (expected_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected decision row %0d col %0d at %0t",
                             got.f.point_row, got.f.point_col, $realtime);
            end else begin
                want = expected_points.pop_front();
                checked_points++;
                if (want.f.is_low) low_points++;
                if (want.frame_done) frames_done++;
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("ERROR: decision %0d mismatch at %0t", checked_points,
                                 $realtime);
                        $display("  exp row %0d col %0d low %0b h %0d risk %0d last %0b done %0b",
                                 want.f.point_row, want.f.point_col, want.f.is_low,
                                 want.f.point_height, want.f.risk_sum, want.last_of_run,
                                 want.frame_done);
                        $display("  got row %0d col %0d low %0b h %0d risk %0d last %0b done %0b",
                                 got.f.point_row, got.f.point_col, got.f.is_low,
                                 got.f.point_height, got.f.risk_sum, got.last_of_run,
                                 got.frame_done);
                    end
                end
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("ERROR: no progress for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Wait until every height is sent and every decision is out, then settle
    task automatic drain;
        do @(posedge i_clk);
        while (!(height_feed.size() == 0 && !i_s_axis_tvalid && expected_points.size() == 0));
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Drain, then program the frame size
    task automatic set_frame_size(input int cols_val, input int rows_val);
        drain();
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= glmrs_pkg::REG_NUM_COLS;
        i_cfg_data <= CFG_DATA_W'(cols_val);
        @(posedge i_clk);
        i_cfg_addr <= glmrs_pkg::REG_NUM_ROWS;
        i_cfg_data <= CFG_DATA_W'(rows_val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cols_reg = cols_val & 8'hFF;
        rows_reg = rows_val & 11'h7FF;
    endtask

    // Queue one whole frame of random heights
    task automatic queue_random_frame(input int cols_val, input int rows_val);
        int n;
        int hi;
        int lo_mode;
        n = clamp_dim(cols_val & 8'hFF, MAX_COLS_DEF) * clamp_dim(rows_val & 11'h7FF, MAX_ROWS_DEF);
        lo_mode = $urandom_range(0, 9);
        hi = (lo_mode == 0) ? 2 : (lo_mode == 1) ? 15 : 9;
        set_frame_size(cols_val, rows_val);
        for (int i = 0; i < n; i++) feed_height(HEIGHT_W'($urandom_range(0, hi)));
        random_items += n;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // 3x3 frame: interior and corner low points
        set_frame_size(3, 3);
        feed_height(4'd0); feed_height(4'd9); feed_height(4'd2);
        feed_height(4'd9); feed_height(4'd1); feed_height(4'd9);
        feed_height(4'd3); feed_height(4'd9); feed_height(4'd3);

        // Zero sizes saturate to a single cell
        set_frame_size(0, 0);
        feed_height(4'd9);

        // Single column
        set_frame_size(1, 3);
        feed_height(4'd4); feed_height(4'd2); feed_height(4'd7);

        // Single row with an equal neighbour pair
        set_frame_size(4, 1);
        feed_height(4'd5); feed_height(4'd5);
        feed_height(4'd9); feed_height(4'd0);

        // Flat 2x2 frame: no low point anywhere
        set_frame_size(2, 2);
        repeat (4) feed_height(4'd8);

        // Random frames, mostly small
        while (random_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) < 7)
                queue_random_frame($urandom_range(1, 10), $urandom_range(1, 6));
            else
                queue_random_frame($urandom_range(11, 40), $urandom_range(1, 3));
        end

        // Widest frame, reached through column saturation
        queue_random_frame(255, 2);

        drain();
        $display("Sent %0d heights over %0d frames; checked %0d decisions, %0d low points.",
                 sent_items, frames_done, checked_points, low_points);
        $display("Frames ran from a single cell up to the full 128 columns, rows up to 6.");
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("Mismatches: %0d", mismatches);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
